@@ rtl/pft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_pkg: shared definitions for the planar frame transform
// Default widths, operation and quadrant codes, CORDIC constants and the
// helper that picks the fraction width of the sine and cosine values.
// ----------------------------------------------------------------------------
package pft_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int ANGLE_BITS   = 16;
    localparam int CURV_W       = 32;
    localparam int ARCLEN_W     = 32;

    // The heading is widened to a 32-bit turn angle before rotation.
    localparam int TURN_W       = 32;
    localparam int CORDIC_STEPS = 30;
    // Datapath width of the CORDIC: Q30 values with headroom for the gain.
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_GAIN  = 652032874;

    // Arctangent of 2^-i in units of 2^32 per full turn.
    localparam logic [TURN_W-1:0] TURN_ATAN [CORDIC_STEPS] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
        32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
        32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0003, 32'h0000_0001
    };

    typedef enum logic {
        OP_LOCAL_TO_GLOBAL = 1'b0,
        OP_GLOBAL_TO_LOCAL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Fraction bits kept in sine and cosine, at most thirty, so that the
    // coordinate width plus the fraction bits stays within sixty bits.
    function automatic int trig_frac(input int coord_width);
        return ((60 - coord_width) < 30) ? (60 - coord_width) : 30;
    endfunction

endpackage

@@ rtl/pft_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_if: pose channels of the planar frame transform
// Valid/ready channels for the pose pair going in and the transformed pose
// coming out; a transaction completes when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pft_in_if #(
    parameter int COORD_WIDTH = pft_pkg::COORD_WIDTH,
    parameter int ANGLE_BITS  = pft_pkg::ANGLE_BITS
);
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic signed [COORD_WIDTH-1:0]       ref_x;
    logic signed [COORD_WIDTH-1:0]       ref_y;
    logic [ANGLE_BITS-1:0]               ref_heading;
    logic signed [COORD_WIDTH-1:0]       tgt_x;
    logic signed [COORD_WIDTH-1:0]       tgt_y;
    logic [ANGLE_BITS-1:0]               tgt_heading;
    logic signed [pft_pkg::CURV_W-1:0]   tgt_curvature;
    logic [pft_pkg::ARCLEN_W-1:0]        tgt_arclen;

    modport source (
        output valid, op, ref_x, ref_y, ref_heading, tgt_x, tgt_y, tgt_heading,
               tgt_curvature, tgt_arclen,
        input  ready
    );
    modport sink (
        input  valid, op, ref_x, ref_y, ref_heading, tgt_x, tgt_y, tgt_heading,
               tgt_curvature, tgt_arclen,
        output ready
    );
endinterface

interface pft_out_if #(
    parameter int COORD_WIDTH = pft_pkg::COORD_WIDTH,
    parameter int ANGLE_BITS  = pft_pkg::ANGLE_BITS
);
    logic                                valid;
    logic                                ready;
    logic signed [COORD_WIDTH-1:0]       out_x;
    logic signed [COORD_WIDTH-1:0]       out_y;
    logic [ANGLE_BITS-1:0]               out_heading;
    logic signed [pft_pkg::CURV_W-1:0]   out_curvature;
    logic [pft_pkg::ARCLEN_W-1:0]        out_arclen;
    logic                                saturated;

    modport source (
        output valid, out_x, out_y, out_heading, out_curvature, out_arclen, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_heading, out_curvature, out_arclen, saturated,
        output ready
    );
endinterface

@@ rtl/planar_frame_transform.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_frame_transform: rigid 2D transform of a pose between frames
// Local to global or global to local transform of a Q16.16 pose by a
// reference pose, with wrapped headings and saturated coordinates.
// ----------------------------------------------------------------------------
// Usage
//   pose_in carries one transaction per pose pair: op, the reference pose and
//   the target pose with its curvature and arc length. pose_out carries one
//   transaction per input transaction, in the same order.
//   Each pose pair passes through the input register, the start register and
//   30 step stages of the sine and cosine pipeline (one CORDIC step per
//   stage), its rounding and quadrant stage, a multiply stage, a sum and
//   rounding stage and the add, clamp and output stage. One pose pair is
//   taken every cycle while the receiver keeps up.
//   Reset clears every valid flag; pose_in.ready is high from the first
//   cycle after reset.
//   When pose_out stalls, the result in hand is held and one further result
//   is caught in a skid register; pose_in.ready then drops and the whole
//   pipeline holds until the receiver takes the held result.
// ----------------------------------------------------------------------------
module planar_frame_transform #(
    parameter int COORD_WIDTH = pft_pkg::COORD_WIDTH,
    parameter int ANGLE_BITS  = pft_pkg::ANGLE_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    pft_in_if.sink       pose_in,
    pft_out_if.source    pose_out
);

    localparam int TRIG_FRAC = pft_pkg::trig_frac(COORD_WIDTH);
    localparam int TRIG_W    = TRIG_FRAC + 3;
    localparam int MUL_W     = COORD_WIDTH + 1;
    localparam int PROD_W    = MUL_W + TRIG_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int ROT_W     = SUM_W - TRIG_FRAC;
    localparam int FIN_W     = ROT_W + 1;
    localparam int CURV_W    = pft_pkg::CURV_W;
    localparam int ARC_W     = pft_pkg::ARCLEN_W;
    localparam int PAY_W     = 1 + 2 * MUL_W + 2 * COORD_WIDTH + ANGLE_BITS + CURV_W + ARC_W;
    localparam int RES_W     = 2 * COORD_WIDTH + ANGLE_BITS + CURV_W + ARC_W + 1;
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (TRIG_FRAC - 1);
    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    // Pipeline advance: every stage before the output register moves unless the skid register is full.
    logic ce;

    // Input register
    logic                           in_valid_reg;
    pft_pkg::op_t                   op_reg;
    logic signed [COORD_WIDTH-1:0]  ref_x_reg;
    logic signed [COORD_WIDTH-1:0]  ref_y_reg;
    logic [ANGLE_BITS-1:0]          ref_heading_reg;
    logic signed [COORD_WIDTH-1:0]  tgt_x_reg;
    logic signed [COORD_WIDTH-1:0]  tgt_y_reg;
    logic [ANGLE_BITS-1:0]          tgt_heading_reg;
    logic signed [CURV_W-1:0]       tgt_curv_reg;
    logic [ARC_W-1:0]               tgt_arclen_reg;

    // Operand preparation
    logic                           g2l;
    logic signed [MUL_W-1:0]        ext_tx;
    logic signed [MUL_W-1:0]        ext_ty;
    logic signed [MUL_W-1:0]        ext_rx;
    logic signed [MUL_W-1:0]        ext_ry;
    logic signed [MUL_W-1:0]        mx_prep;
    logic signed [MUL_W-1:0]        my_prep;
    logic signed [COORD_WIDTH-1:0]  add_x_prep;
    logic signed [COORD_WIDTH-1:0]  add_y_prep;
    logic [ANGLE_BITS-1:0]          head_prep;
    logic [ARC_W-1:0]               arc_prep;
    logic [PAY_W-1:0]               prep_pay;

    // Trigonometry output
    logic                           trig_valid;
    logic signed [TRIG_W-1:0]       trig_cos;
    logic signed [TRIG_W-1:0]       trig_sin;
    logic [PAY_W-1:0]               trig_pay;
    logic                           t_op;
    logic signed [MUL_W-1:0]        t_mx;
    logic signed [MUL_W-1:0]        t_my;
    logic signed [COORD_WIDTH-1:0]  t_add_x;
    logic signed [COORD_WIDTH-1:0]  t_add_y;
    logic [ANGLE_BITS-1:0]          t_head;
    logic signed [CURV_W-1:0]       t_curv;
    logic [ARC_W-1:0]               t_arc;

    // Multiply stage
    logic                           mul_valid_reg;
    logic signed [PROD_W-1:0]       pcx_reg;
    logic signed [PROD_W-1:0]       psy_reg;
    logic signed [PROD_W-1:0]       psx_reg;
    logic signed [PROD_W-1:0]       pcy_reg;
    pft_pkg::op_t                   op_m_reg;
    logic signed [COORD_WIDTH-1:0]  add_x_m_reg;
    logic signed [COORD_WIDTH-1:0]  add_y_m_reg;
    logic [ANGLE_BITS-1:0]          head_m_reg;
    logic signed [CURV_W-1:0]       curv_m_reg;
    logic [ARC_W-1:0]               arc_m_reg;

    // Sum and rounding stage
    logic signed [SUM_W-1:0]        sum_x;
    logic signed [SUM_W-1:0]        sum_y;
    logic signed [SUM_W-1:0]        sum_x_rnd;
    logic signed [SUM_W-1:0]        sum_y_rnd;
    logic                           sum_valid_reg;
    logic signed [ROT_W-1:0]        rot_x_reg;
    logic signed [ROT_W-1:0]        rot_y_reg;
    logic signed [COORD_WIDTH-1:0]  add_x_s_reg;
    logic signed [COORD_WIDTH-1:0]  add_y_s_reg;
    logic [ANGLE_BITS-1:0]          head_s_reg;
    logic signed [CURV_W-1:0]       curv_s_reg;
    logic [ARC_W-1:0]               arc_s_reg;

    // Final add, clamp and output
    logic [COORD_WIDTH:0]           clamp_x;
    logic [COORD_WIDTH:0]           clamp_y;
    logic [RES_W-1:0]               fin_vec;
    logic                           out_valid_reg;
    logic [RES_W-1:0]               out_data_reg;
    logic                           skid_valid_reg;
    logic [RES_W-1:0]               skid_data_reg;

    // Returns the saturation flag above the clamped coordinate.
    function automatic logic [COORD_WIDTH:0] clamp_coord(input logic signed [FIN_W-1:0] v);
        logic [FIN_W-COORD_WIDTH:0] top;
        top = v[FIN_W-1:COORD_WIDTH-1];
        if ((&top) || !(|top))
        begin
            return {1'b0, v[COORD_WIDTH-1:0]};
        end
        return {1'b1, v[FIN_W-1] ? COORD_MIN : COORD_MAX};
    endfunction

    assign ce            = !skid_valid_reg;
    assign pose_in.ready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            in_valid_reg  <= pose_in.valid;
            mul_valid_reg <= trig_valid;
            sum_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            op_reg          <= pft_pkg::op_t'(pose_in.op);
            ref_x_reg       <= pose_in.ref_x;
            ref_y_reg       <= pose_in.ref_y;
            ref_heading_reg <= pose_in.ref_heading;
            tgt_x_reg       <= pose_in.tgt_x;
            tgt_y_reg       <= pose_in.tgt_y;
            tgt_heading_reg <= pose_in.tgt_heading;
            tgt_curv_reg    <= pose_in.tgt_curvature;
            tgt_arclen_reg  <= pose_in.tgt_arclen;
        end
    end

    // Global to local works on the full-width difference to the reference.
    assign g2l    = (op_reg == pft_pkg::OP_GLOBAL_TO_LOCAL);
    assign ext_tx = {tgt_x_reg[COORD_WIDTH-1], tgt_x_reg};
    assign ext_ty = {tgt_y_reg[COORD_WIDTH-1], tgt_y_reg};
    assign ext_rx = {ref_x_reg[COORD_WIDTH-1], ref_x_reg};
    assign ext_ry = {ref_y_reg[COORD_WIDTH-1], ref_y_reg};

    assign mx_prep    = g2l ? (ext_tx - ext_rx) : ext_tx;
    assign my_prep    = g2l ? (ext_ty - ext_ry) : ext_ty;
    assign add_x_prep = g2l ? '0 : ref_x_reg;
    assign add_y_prep = g2l ? '0 : ref_y_reg;
    assign head_prep  = g2l ? ANGLE_BITS'(tgt_heading_reg - ref_heading_reg)
                            : ANGLE_BITS'(tgt_heading_reg + ref_heading_reg);
    assign arc_prep   = g2l ? '0 : tgt_arclen_reg;
    assign prep_pay   = {op_reg, mx_prep, my_prep, add_x_prep, add_y_prep, head_prep,
                         tgt_curv_reg, arc_prep};

    pft_cordic #(
        .ANGLE_BITS (ANGLE_BITS),
        .TRIG_FRAC  (TRIG_FRAC),
        .PAY_W      (PAY_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ce),
        .in_valid  (in_valid_reg),
        .angle     (ref_heading_reg),
        .in_pay    (prep_pay),
        .out_valid (trig_valid),
        .cos_val   (trig_cos),
        .sin_val   (trig_sin),
        .out_pay   (trig_pay)
    );

    assign {t_op, t_mx, t_my, t_add_x, t_add_y, t_head, t_curv, t_arc} = trig_pay;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pcx_reg     <= t_mx * trig_cos;
            psy_reg     <= t_my * trig_sin;
            psx_reg     <= t_mx * trig_sin;
            pcy_reg     <= t_my * trig_cos;
            op_m_reg    <= pft_pkg::op_t'(t_op);
            add_x_m_reg <= t_add_x;
            add_y_m_reg <= t_add_y;
            head_m_reg  <= t_head;
            curv_m_reg  <= t_curv;
            arc_m_reg   <= t_arc;
        end
    end

    always_comb
    begin
        if (op_m_reg == pft_pkg::OP_GLOBAL_TO_LOCAL)
        begin
            sum_x = SUM_W'(pcx_reg) + SUM_W'(psy_reg);
            sum_y = SUM_W'(pcy_reg) - SUM_W'(psx_reg);
        end
        else
        begin
            sum_x = SUM_W'(pcx_reg) - SUM_W'(psy_reg);
            sum_y = SUM_W'(psx_reg) + SUM_W'(pcy_reg);
        end
    end

    // Round half up, then drop the trigonometric fraction bits.
    assign sum_x_rnd = sum_x + RND_HALF;
    assign sum_y_rnd = sum_y + RND_HALF;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rot_x_reg   <= sum_x_rnd[SUM_W-1:TRIG_FRAC];
            rot_y_reg   <= sum_y_rnd[SUM_W-1:TRIG_FRAC];
            add_x_s_reg <= add_x_m_reg;
            add_y_s_reg <= add_y_m_reg;
            head_s_reg  <= head_m_reg;
            curv_s_reg  <= curv_m_reg;
            arc_s_reg   <= arc_m_reg;
        end
    end

    assign clamp_x = clamp_coord(FIN_W'(rot_x_reg) + FIN_W'(add_x_s_reg));
    assign clamp_y = clamp_coord(FIN_W'(rot_y_reg) + FIN_W'(add_y_s_reg));
    assign fin_vec = {clamp_x[COORD_WIDTH-1:0], clamp_y[COORD_WIDTH-1:0], head_s_reg,
                      curv_s_reg, arc_s_reg, clamp_x[COORD_WIDTH] | clamp_y[COORD_WIDTH]};

    // Output register with a skid register behind it. While the skid
    // register is full the pipeline holds, so a result only arrives here
    // when ce is high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pose_out.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= sum_valid_reg;
            end
        end
        else if (sum_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pose_out.ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : fin_vec;
        end
        else if (ce)
        begin
            skid_data_reg <= fin_vec;
        end
    end

    assign pose_out.valid = out_valid_reg;
    assign {pose_out.out_x, pose_out.out_y, pose_out.out_heading, pose_out.out_curvature,
            pose_out.out_arclen, pose_out.saturated} = out_data_reg;

endmodule

@@ rtl/pft_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_cordic: pipelined cosine and sine of a binary angle
// Quadrant reduction, one CORDIC rotation step per stage, then rounding and
// quadrant correction. A payload word travels alongside each angle.
// ----------------------------------------------------------------------------
module pft_cordic #(
    parameter int ANGLE_BITS = pft_pkg::ANGLE_BITS,
    parameter int TRIG_FRAC  = pft_pkg::trig_frac(pft_pkg::COORD_WIDTH),
    parameter int PAY_W      = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [ANGLE_BITS-1:0]        angle,
    input  logic [PAY_W-1:0]             in_pay,
    output logic                         out_valid,
    output logic signed [TRIG_FRAC+2:0]  cos_val,
    output logic signed [TRIG_FRAC+2:0]  sin_val,
    output logic [PAY_W-1:0]             out_pay
);

    localparam int STEPS     = pft_pkg::CORDIC_STEPS;
    localparam int CW        = pft_pkg::CORDIC_W;
    localparam int TW        = pft_pkg::TURN_W;
    localparam int TRIG_W    = TRIG_FRAC + 3;
    localparam int RND_SHIFT = 30 - TRIG_FRAC;
    localparam logic signed [CW-1:0] GAIN = CW'(pft_pkg::CORDIC_GAIN);

    logic [TW-1:0]          turn;
    logic [TW-1:0]          biased;
    logic [TW-1:0]          resid;
    pft_pkg::quad_t         quad;
    logic signed [CW-1:0]   z_init;

    logic [STEPS+1:0]       valid_reg;
    logic signed [CW-1:0]   x_reg [STEPS+1];
    logic signed [CW-1:0]   y_reg [STEPS+1];
    logic signed [CW-1:0]   z_reg [STEPS+1];
    pft_pkg::quad_t         quad_reg [STEPS+1];
    logic [PAY_W-1:0]       pay_reg [STEPS+1];

    logic signed [CW-1:0]   x_next [STEPS];
    logic signed [CW-1:0]   y_next [STEPS];
    logic signed [CW-1:0]   z_next [STEPS];

    logic signed [CW-1:0]   x_rnd;
    logic signed [CW-1:0]   y_rnd;
    logic signed [TRIG_W-1:0] xr;
    logic signed [TRIG_W-1:0] yr;
    logic signed [TRIG_W-1:0] cos_next;
    logic signed [TRIG_W-1:0] sin_next;

    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic [PAY_W-1:0]         out_pay_reg;

    // Nearest quarter turn and a residual within one eighth of a turn.
    assign turn   = {angle, {(TW - ANGLE_BITS){1'b0}}};
    assign biased = turn + (TW'(1) << (TW - 3));
    assign quad   = pft_pkg::quad_t'(biased[TW-1:TW-2]);
    assign resid  = turn - {biased[TW-1:TW-2], {(TW - 2){1'b0}}};
    assign z_init = {{(CW - TW){resid[TW-1]}}, resid};

    always_comb
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            if (z_reg[i] >= 0)
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - $signed({{(CW - TW){1'b0}}, pft_pkg::TURN_ATAN[i]});
            end
            else
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + $signed({{(CW - TW){1'b0}}, pft_pkg::TURN_ATAN[i]});
            end
        end
    end

    generate
        if (RND_SHIFT == 0)
        begin : g_no_round
            assign x_rnd = x_reg[STEPS];
            assign y_rnd = y_reg[STEPS];
        end
        else
        begin : g_round
            localparam logic signed [CW-1:0] HALF = CW'(1) <<< (RND_SHIFT - 1);
            assign x_rnd = (x_reg[STEPS] + HALF) >>> RND_SHIFT;
            assign y_rnd = (y_reg[STEPS] + HALF) >>> RND_SHIFT;
        end
    endgenerate

    assign xr = x_rnd[TRIG_W-1:0];
    assign yr = y_rnd[TRIG_W-1:0];

    always_comb
    begin
        case (quad_reg[STEPS])
            pft_pkg::QUAD_0:
            begin
                cos_next = xr;
                sin_next = yr;
            end
            pft_pkg::QUAD_1:
            begin
                cos_next = -yr;
                sin_next = xr;
            end
            pft_pkg::QUAD_2:
            begin
                cos_next = -xr;
                sin_next = -yr;
            end
            pft_pkg::QUAD_3:
            begin
                cos_next = yr;
                sin_next = -xr;
            end
            default:
            begin
                cos_next = '0;
                sin_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STEPS:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_init;
            quad_reg[0] <= quad;
            pay_reg[0]  <= in_pay;
            for (int i = 0; i < STEPS; i++)
            begin
                x_reg[i+1]    <= x_next[i];
                y_reg[i+1]    <= y_next[i];
                z_reg[i+1]    <= z_next[i];
                quad_reg[i+1] <= quad_reg[i];
                pay_reg[i+1]  <= pay_reg[i];
            end
            cos_reg     <= cos_next;
            sin_reg     <= sin_next;
            out_pay_reg <= pay_reg[STEPS];
        end
    end

    assign out_valid = valid_reg[STEPS+1];
    assign cos_val   = cos_reg;
    assign sin_val   = sin_reg;
    assign out_pay   = out_pay_reg;

endmodule

@@ rtl/pft_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_checker: port-level checks for the planar frame transform
// Tracks transactions in flight and checks the output hold, the pipeline
// capacity and the back-pressure behaviour seen at the ports.
// ----------------------------------------------------------------------------
module pft_checker #(
    parameter int COORD_WIDTH = pft_pkg::COORD_WIDTH,
    parameter int ANGLE_BITS  = pft_pkg::ANGLE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [COORD_WIDTH-1:0]          out_x,
    input  logic [COORD_WIDTH-1:0]          out_y,
    input  logic [ANGLE_BITS-1:0]           out_heading,
    input  logic [pft_pkg::CURV_W-1:0]      out_curvature,
    input  logic [pft_pkg::ARCLEN_W-1:0]    out_arclen,
    input  logic                            saturated
);

    // Input register, CORDIC start register, CORDIC steps, trig, multiply, sum,
    // output and skid registers.
    localparam int CAPACITY = pft_pkg::CORDIC_STEPS + 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1) + 1;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign count_next = count_reg + CNT_W'(in_valid && in_ready)
                                  - CNT_W'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while the receiver stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable({out_x, out_y, out_heading, out_curvature, out_arclen, saturated}))
        else $error("result changed while the receiver stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != '0)
        else $error("result offered with no transaction in flight");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("more transactions in flight than the pipeline holds");

    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input held off without a stalled result");

endmodule

bind planar_frame_transform pft_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_BITS  (ANGLE_BITS)
) u_pft_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pose_in.valid),
    .in_ready      (pose_in.ready),
    .out_valid     (pose_out.valid),
    .out_ready     (pose_out.ready),
    .out_x         (pose_out.out_x),
    .out_y         (pose_out.out_y),
    .out_heading   (pose_out.out_heading),
    .out_curvature (pose_out.out_curvature),
    .out_arclen    (pose_out.out_arclen),
    .saturated     (pose_out.saturated)
);
